// ===== rtl/ipv4rhf_pkg.sv =====
// constants and codes shared by the ipv4 receive header filter
// no dependencies

package ipv4rhf_pkg;

    localparam logic [31:0] LOCAL_ADDRESS_RESET = 32'h0A00_0002;
    localparam logic [15:0] ETHERTYPE_IPV4      = 16'h0800;
    localparam logic [15:0] NO_FRAG_MASK        = 16'h3FFF;
    localparam logic [15:0] SUM_ALL_ONES        = 16'hFFFF;
    localparam logic [3:0]  IP_VERSION_4        = 4'd4;
    localparam logic [15:0] ETH_HDR_BYTES       = 16'd14;
    localparam logic [15:0] MIN_FRAME_LAST_IDX  = 16'd33;
    localparam logic [5:0]  MIN_HDR_BYTES       = 6'd20;
    localparam logic [15:0] COUNT_MAX           = 16'hFFFF;

    // byte positions within the frame
    localparam logic [15:0] POS_ETYPE_HI = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO = 16'd13;
    localparam logic [15:0] POS_VER_IHL  = 16'd14;
    localparam logic [15:0] POS_TLEN_HI  = 16'd16;
    localparam logic [15:0] POS_TLEN_LO  = 16'd17;
    localparam logic [15:0] POS_FRAG_HI  = 16'd20;
    localparam logic [15:0] POS_FRAG_LO  = 16'd21;
    localparam logic [15:0] POS_PROTO    = 16'd23;
    localparam logic [15:0] POS_DST_0    = 16'd30;
    localparam logic [15:0] POS_DST_3    = 16'd33;

    typedef enum logic [3:0] {
        RSN_OK        = 4'd0,
        RSN_SHORT     = 4'd1,
        RSN_ETHERTYPE = 4'd2,
        RSN_VERSION   = 4'd3,
        RSN_IHL       = 4'd4,
        RSN_TRUNCATED = 4'd5,
        RSN_TOTAL_LEN = 4'd6,
        RSN_ADDRESS   = 4'd7,
        RSN_CHECKSUM  = 4'd8,
        RSN_FRAGMENT  = 4'd9
    } reason_t;

endpackage

// ===== rtl/ipv4_receive_header_filter_top.sv =====
// ipv4 receive header filter: byte-wide frame in, one verdict per frame out
// depends on ipv4rhf_pkg
//
// channel   direction  handshake                  payload
// frame     in         frame_valid / frame_stall  data_byte, last_byte
// verdict   out        verdict_valid / verdict_stall
//                                                 accepted, reason, protocol,
//                                                 header_length, payload_length
// cfg       in         cfg_valid / cfg_ready      cfg_data (local address)
//
// one byte per cycle while not stalled; each byte passes the input register, and
// the verdict is loaded into the result register as the last byte leaves it
// all header capture, checksum add and checks sit between those two registers
// non-last bytes keep flowing while a verdict waits; a last byte waits only
// if the result register is still held by verdict_stall
// reset clears all frame state and sets the local address to 10.0.0.2

module ipv4_receive_header_filter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        verdict_valid,
    input  logic        verdict_stall,
    output logic        accepted,
    output logic [3:0]  reason,
    output logic [7:0]  protocol,
    output logic [5:0]  header_length,
    output logic [15:0] payload_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] local_addr_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] dst_reg, dst_next;

    logic        out_valid_reg;
    logic        out_accepted_reg;
    logic [3:0]  out_reason_reg;
    logic [7:0]  out_proto_reg;
    logic [5:0]  out_hlen_reg;
    logic [15:0] out_plen_reg;

    logic        advance;
    logic        finish;
    logic [15:0] idx;
    logic [15:0] off;
    logic [5:0]  hlen;
    logic        in_header;
    logic [16:0] sum_wide;
    logic [15:0] sum_fold;
    logic [16:0] idx_wide;
    ipv4rhf_pkg::reason_t rsn;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= ipv4rhf_pkg::LOCAL_ADDRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_addr_reg <= cfg_data;
        end
    end

    // a last byte needs the result register free
    assign advance     = in_valid_reg
                       && (!in_last_reg || !out_valid_reg || !verdict_stall);
    assign frame_stall = in_valid_reg && !advance;
    assign finish      = advance && in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!frame_stall)
        begin
            in_valid_reg <= frame_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!frame_stall)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    assign idx      = count_reg;
    assign idx_wide = {1'b0, idx};

    // header field capture for the current byte
    always_comb
    begin
        etype_next   = etype_reg;
        ver_ihl_next = ver_ihl_reg;
        tlen_next    = tlen_reg;
        frag_next    = frag_reg;
        proto_next   = proto_reg;
        dst_next     = dst_reg;
        case (idx)
            ipv4rhf_pkg::POS_ETYPE_HI: etype_next   = {in_byte_reg, etype_reg[7:0]};
            ipv4rhf_pkg::POS_ETYPE_LO: etype_next   = {etype_reg[15:8], in_byte_reg};
            ipv4rhf_pkg::POS_VER_IHL:  ver_ihl_next = in_byte_reg;
            ipv4rhf_pkg::POS_TLEN_HI:  tlen_next    = {in_byte_reg, tlen_reg[7:0]};
            ipv4rhf_pkg::POS_TLEN_LO:  tlen_next    = {tlen_reg[15:8], in_byte_reg};
            ipv4rhf_pkg::POS_FRAG_HI:  frag_next    = {in_byte_reg, frag_reg[7:0]};
            ipv4rhf_pkg::POS_FRAG_LO:  frag_next    = {frag_reg[15:8], in_byte_reg};
            ipv4rhf_pkg::POS_PROTO:    proto_next   = in_byte_reg;
            default: ;
        endcase
        if (idx >= ipv4rhf_pkg::POS_DST_0 && idx <= ipv4rhf_pkg::POS_DST_3)
        begin
            dst_next = {dst_reg[23:0], in_byte_reg};
        end
    end

    // checksum over header words, ihl taken after this byte's capture
    assign hlen      = {ver_ihl_next[3:0], 2'b00};
    assign off       = idx - ipv4rhf_pkg::ETH_HDR_BYTES;
    assign in_header = (idx >= ipv4rhf_pkg::ETH_HDR_BYTES) && (off < {10'd0, hlen});
    assign sum_wide  = {1'b0, sum_reg} + {1'b0, held_reg, in_byte_reg};
    assign sum_fold  = sum_wide[15:0] + {15'd0, sum_wide[16]};

    always_comb
    begin
        held_next = held_reg;
        sum_next  = sum_reg;
        if (in_header)
        begin
            // even offset opens a word, odd offset closes it
            if (!off[0])
            begin
                held_next = in_byte_reg;
            end
            else
            begin
                sum_next = sum_fold;
            end
        end
    end

    always_comb
    begin
        if (idx < ipv4rhf_pkg::MIN_FRAME_LAST_IDX)
            rsn = ipv4rhf_pkg::RSN_SHORT;
        else if (etype_next != ipv4rhf_pkg::ETHERTYPE_IPV4)
            rsn = ipv4rhf_pkg::RSN_ETHERTYPE;
        else if (ver_ihl_next[7:4] != ipv4rhf_pkg::IP_VERSION_4)
            rsn = ipv4rhf_pkg::RSN_VERSION;
        else if (hlen < ipv4rhf_pkg::MIN_HDR_BYTES)
            rsn = ipv4rhf_pkg::RSN_IHL;
        else if (idx_wide < 17'd13 + {11'd0, hlen})
            rsn = ipv4rhf_pkg::RSN_TRUNCATED;
        else if (tlen_next < {10'd0, hlen} || {1'b0, tlen_next} + 17'd13 > idx_wide)
            rsn = ipv4rhf_pkg::RSN_TOTAL_LEN;
        else if (dst_next != local_addr_reg)
            rsn = ipv4rhf_pkg::RSN_ADDRESS;
        else if (sum_next != ipv4rhf_pkg::SUM_ALL_ONES)
            rsn = ipv4rhf_pkg::RSN_CHECKSUM;
        else if ((frag_next & ipv4rhf_pkg::NO_FRAG_MASK) != 16'd0)
            rsn = ipv4rhf_pkg::RSN_FRAGMENT;
        else
            rsn = ipv4rhf_pkg::RSN_OK;
    end

    always_comb
    begin
        if (in_last_reg)
            count_next = 16'd0;
        else if (idx == ipv4rhf_pkg::COUNT_MAX)
            count_next = idx;
        else
            count_next = idx + 16'd1;
    end

    // frame state, cleared after every last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 16'd0;
            sum_reg     <= 16'd0;
            held_reg    <= 8'd0;
            etype_reg   <= 16'd0;
            ver_ihl_reg <= 8'd0;
            tlen_reg    <= 16'd0;
            frag_reg    <= 16'd0;
            proto_reg   <= 8'd0;
            dst_reg     <= 32'd0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            if (in_last_reg)
            begin
                sum_reg     <= 16'd0;
                held_reg    <= 8'd0;
                etype_reg   <= 16'd0;
                ver_ihl_reg <= 8'd0;
                tlen_reg    <= 16'd0;
                frag_reg    <= 16'd0;
                proto_reg   <= 8'd0;
                dst_reg     <= 32'd0;
            end
            else
            begin
                sum_reg     <= sum_next;
                held_reg    <= held_next;
                etype_reg   <= etype_next;
                ver_ihl_reg <= ver_ihl_next;
                tlen_reg    <= tlen_next;
                frag_reg    <= frag_next;
                proto_reg   <= proto_next;
                dst_reg     <= dst_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!verdict_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_accepted_reg <= (rsn == ipv4rhf_pkg::RSN_OK);
            out_reason_reg   <= rsn;
            out_proto_reg    <= proto_next;
            out_hlen_reg     <= hlen;
            out_plen_reg     <= (rsn == ipv4rhf_pkg::RSN_OK)
                              ? (tlen_next - {10'd0, hlen}) : 16'd0;
        end
    end

    assign verdict_valid  = out_valid_reg;
    assign accepted       = out_accepted_reg;
    assign reason         = out_reason_reg;
    assign protocol       = out_proto_reg;
    assign header_length  = out_hlen_reg;
    assign payload_length = out_plen_reg;

    // a new verdict only follows a last byte moving out of the input register
    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(verdict_valid) |-> $past(finish))
        else $error("verdict without a last byte");

    a_accept_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_valid |-> (accepted == (reason == ipv4rhf_pkg::RSN_OK)))
        else $error("accepted flag disagrees with reason");

    a_reject_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && !accepted) |-> (payload_length == 16'd0))
        else $error("rejected frame reports a payload length");

    a_accept_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
        (verdict_valid && accepted) |-> (header_length >= ipv4rhf_pkg::MIN_HDR_BYTES))
        else $error("accepted frame with short header");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (count_reg == 16'd0 && sum_reg == 16'd0))
        else $error("frame state not cleared after last byte");

endmodule

// ===== verif/tb_ipv4_receive_header_filter_top.sv =====
`timescale 1ns / 100ps
// testbench for ipv4_receive_header_filter_top: byte-wide frames with random gaps in,
// each verdict checked against an in-bench model of the ipv4 header checks
// depends on ipv4rhf_pkg and the filter rtl

module tb_ipv4_receive_header_filter_top;

    localparam logic [31:0] BOOT_ADDRESS   = 32'h0A00_0002;
    localparam logic [15:0] ETYPE_IP       = 16'h0800;
    localparam logic [15:0] FRAG_BITS      = 16'h3FFF;
    localparam logic [15:0] GOOD_SUM       = 16'hFFFF;
    localparam logic [15:0] COUNT_TOP      = 16'hFFFF;
    localparam logic [3:0]  IPV4_VER       = 4'd4;
    localparam int          ETH_LEN        = 14;
    localparam int          SHORTEST_FRAME = 34;
    localparam int          SHORTEST_HDR   = 20;
    localparam int          IDLE_PERCENT   = 35;
    localparam int          LONG_HOLD      = 400;

    typedef struct packed {
        logic                 accepted;
        ipv4rhf_pkg::reason_t reason;
        logic [7:0]           protocol;
        logic [5:0]           header_length;
        logic [15:0]          payload_length;
    } verdict_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct {
        int unsigned n_bytes;
        bit          raw;
        bit          rand_fill;
        logic [7:0]  fill;
        logic [15:0] etype;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] tlen;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] dst;
        bit          bad_sum;
    } packet_spec_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        frame_valid    = 1'b0;
    logic        frame_stall;
    logic [7:0]  data_byte      = 8'd0;
    logic        last_byte      = 1'b0;
    logic        verdict_valid;
    logic        verdict_stall  = 1'b0;
    logic        accepted;
    logic [3:0]  reason;
    logic [7:0]  protocol;
    logic [5:0]  header_length;
    logic [15:0] payload_length;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data       = 32'd0;

    // model state: per-frame capture plus the address register copy
    logic [31:0] local_address_now = BOOT_ADDRESS;
    logic [15:0] seen_count  = '0;
    logic [15:0] hdr_sum     = '0;
    logic [7:0]  pending_hi  = '0;
    logic [15:0] etype_cap   = '0;
    logic [7:0]  ver_ihl_cap = '0;
    logic [15:0] tlen_cap    = '0;
    logic [15:0] frag_cap    = '0;
    logic [7:0]  proto_cap   = '0;
    logic [31:0] dst_cap     = '0;

    frame_byte_t bytes_to_send[$];
    verdict_t    verdicts_due[$];

    int unsigned errors        = 0;
    int unsigned bytes_taken   = 0;
    int unsigned verdicts_seen = 0;
    int unsigned accepts_seen  = 0;
    int unsigned settings_used = 0;
    int unsigned hold_cycles   = 0;
    int unsigned hold_mark     = 4;
    int unsigned cycle_no      = 0;
    bit          reasons_hit[16];

    // both sides stop random idling while cycle_no % 4000 is in [600, 1400)
    wire quiet = (cycle_no % 4000) >= 600 && (cycle_no % 4000) < 1400;

    ipv4_receive_header_filter_top u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .verdict_valid  (verdict_valid),
        .verdict_stall  (verdict_stall),
        .accepted       (accepted),
        .reason         (reason),
        .protocol       (protocol),
        .header_length  (header_length),
        .payload_length (payload_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
    end

    // header capture and checks for one frame byte; returns 1 when a verdict is due
    function automatic bit absorb_byte(input logic [7:0] b, input logic lastb,
                                       output verdict_t v);
        int unsigned idx;
        int unsigned hl;
        int unsigned len;
        int unsigned tl;
        logic [31:0] s;
        ipv4rhf_pkg::reason_t why;
        idx = seen_count;
        case (idx)
            12: etype_cap[15:8] = b;
            13: etype_cap[7:0]  = b;
            14: ver_ihl_cap     = b;
            16: tlen_cap[15:8]  = b;
            17: tlen_cap[7:0]   = b;
            20: frag_cap[15:8]  = b;
            21: frag_cap[7:0]   = b;
            23: proto_cap       = b;
            30, 31, 32, 33: dst_cap = {dst_cap[23:0], b};
            default: ;
        endcase
        hl = int'(ver_ihl_cap[3:0]) * 4;
        if (idx >= ETH_LEN && idx - ETH_LEN < hl)
        begin
            if (((idx - ETH_LEN) & 1) == 0)
                pending_hi = b;
            else
            begin
                s = {16'd0, hdr_sum} + {16'd0, pending_hi, b};
                s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
                hdr_sum = s[15:0];
            end
        end
        if (seen_count != COUNT_TOP)
            seen_count = seen_count + 16'd1;
        v = '0;
        if (!lastb)
            return 1'b0;

        len = idx + 1;
        tl  = tlen_cap;
        if (len < SHORTEST_FRAME)
            why = ipv4rhf_pkg::RSN_SHORT;
        else if (etype_cap != ETYPE_IP)
            why = ipv4rhf_pkg::RSN_ETHERTYPE;
        else if (ver_ihl_cap[7:4] != IPV4_VER)
            why = ipv4rhf_pkg::RSN_VERSION;
        else if (hl < SHORTEST_HDR)
            why = ipv4rhf_pkg::RSN_IHL;
        else if (len < ETH_LEN + hl)
            why = ipv4rhf_pkg::RSN_TRUNCATED;
        else if (tl < hl || tl > len - ETH_LEN)
            why = ipv4rhf_pkg::RSN_TOTAL_LEN;
        else if (dst_cap != local_address_now)
            why = ipv4rhf_pkg::RSN_ADDRESS;
        else if (hdr_sum != GOOD_SUM)
            why = ipv4rhf_pkg::RSN_CHECKSUM;
        else if ((frag_cap & FRAG_BITS) != 16'd0)
            why = ipv4rhf_pkg::RSN_FRAGMENT;
        else
            why = ipv4rhf_pkg::RSN_OK;

        v.accepted       = (why == ipv4rhf_pkg::RSN_OK);
        v.reason         = why;
        v.protocol       = proto_cap;
        v.header_length  = hl[5:0];
        v.payload_length = (why == ipv4rhf_pkg::RSN_OK) ? 16'(tl - hl) : 16'd0;

        seen_count  = '0;
        hdr_sum     = '0;
        pending_hi  = '0;
        etype_cap   = '0;
        ver_ihl_cap = '0;
        tlen_cap    = '0;
        frag_cap    = '0;
        proto_cap   = '0;
        dst_cap     = '0;
        return 1'b1;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // frame side: one byte per transfer, random gaps between transfers
    always @(posedge clk or negedge rst_n)
    begin : drive_frames
        frame_byte_t nxt;
        verdict_t    v;
        bit          idle;
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
            data_byte   <= 8'd0;
            last_byte   <= 1'b0;
        end
        else
        begin
            if (frame_valid && !frame_stall)
            begin
                bytes_taken++;
                if (absorb_byte(data_byte, last_byte, v))
                    verdicts_due.push_back(v);
            end
            if (!frame_valid || !frame_stall)
            begin
                idle = !quiet && ($urandom_range(99) < IDLE_PERCENT);
                if (bytes_to_send.size() != 0 && !idle)
                begin
                    nxt = bytes_to_send.pop_front();
                    frame_valid <= 1'b1;
                    data_byte   <= nxt.data;
                    last_byte   <= nxt.last;
                end
                else
                    frame_valid <= 1'b0;
            end
        end
    end

    // verdict side: check each transfer, random stalls plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin : check_verdicts
        verdict_t want;
        if (!rst_n)
            verdict_stall <= 1'b0;
        else
        begin
            if (verdict_valid && !verdict_stall)
            begin
                verdicts_seen++;
                if (verdicts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: verdict with none expected, actual reason %0d", $time, reason);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    reasons_hit[want.reason] = 1'b1;
                    if (want.accepted)
                        accepts_seen++;
                    compare_field("accepted", want.accepted, accepted);
                    compare_field("reason", want.reason, reason);
                    compare_field("protocol", want.protocol, protocol);
                    compare_field("header_length", want.header_length, header_length);
                    compare_field("payload_length", want.payload_length, payload_length);
                end
            end
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                verdict_stall <= 1'b1;
            end
            else if (verdicts_seen >= hold_mark)
            begin
                hold_mark   = (hold_mark == 4) ? 12 : 32'hFFFF_FFFF;
                hold_cycles = LONG_HOLD;
                verdict_stall <= 1'b1;
            end
            else
                verdict_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    function automatic packet_spec_t sane_packet(int unsigned words, int unsigned extra);
        packet_spec_t p;
        p.n_bytes   = ETH_LEN + words * 4 + extra;
        p.raw       = 1'b0;
        p.rand_fill = 1'b1;
        p.fill      = 8'd0;
        p.etype     = ETYPE_IP;
        p.ver       = IPV4_VER;
        p.ihl       = words[3:0];
        p.tlen      = 16'($urandom_range(words * 4, p.n_bytes - ETH_LEN));
        p.frag      = 16'd0;
        p.proto     = 8'($urandom);
        p.dst       = local_address_now;
        p.bad_sum   = 1'b0;
        return p;
    endfunction

    task automatic send_packet(packet_spec_t p);
        logic [7:0]  octets[];
        logic [31:0] s;
        frame_byte_t fb;
        octets = new[p.n_bytes < 74 ? 74 : p.n_bytes];
        for (int k = 0; k < octets.size(); k++)
            octets[k] = p.rand_fill ? 8'($urandom) : p.fill;
        if (!p.raw)
        begin
            {octets[12], octets[13]} = p.etype;
            octets[14] = {p.ver, p.ihl};
            {octets[16], octets[17]} = p.tlen;
            {octets[20], octets[21]} = p.frag;
            octets[23] = p.proto;
            {octets[30], octets[31], octets[32], octets[33]} = p.dst;
            // header checksum word sits at header offset 10
            s = 0;
            for (int k = 0; k < p.ihl * 2; k++)
            begin
                if (k != 5)
                begin
                    s = s + {16'd0, octets[14 + 2 * k], octets[15 + 2 * k]};
                    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
                end
            end
            {octets[24], octets[25]} = ~s[15:0] ^ (p.bad_sum ? 16'h0100 : 16'h0000);
        end
        for (int k = 0; k < p.n_bytes; k++)
        begin
            fb.data = octets[k];
            fb.last = (k == p.n_bytes - 1);
            bytes_to_send.push_back(fb);
        end
    endtask

    task automatic queue_random_traffic(int unsigned byte_goal, int unsigned frame_goal);
        packet_spec_t p;
        int unsigned  bytes_out;
        int unsigned  frames_out;
        int unsigned  pick;
        bytes_out  = 0;
        frames_out = 0;
        while (bytes_out < byte_goal || frames_out < frame_goal)
        begin
            pick = $urandom_range(99);
            p = sane_packet($urandom_range(3) == 0 ? $urandom_range(5, 15) : 5,
                            $urandom_range(3) == 0 ? $urandom_range(0, 120)
                                                   : $urandom_range(0, 12));
            p.frag = {2'($urandom), 14'd0};
            if (pick < 10)
            begin
                p.raw     = 1'b1;
                p.n_bytes = $urandom_range(1, 70);
            end
            else if (pick < 18)
                p.n_bytes = $urandom_range(1, SHORTEST_FRAME - 1);
            else if (pick < 48)
            begin
                case ($urandom_range(7))
                    0: p.etype = 16'($urandom);
                    1: p.ver = 4'($urandom);
                    2: p.ihl = 4'($urandom_range(0, 4));
                    3:
                    begin
                        p.ihl     = 4'd15;
                        p.n_bytes = $urandom_range(SHORTEST_FRAME, 73);
                    end
                    4: p.tlen = $urandom_range(1) ? 16'($urandom_range(0, p.ihl * 4 - 1))
                                                  : 16'(p.n_bytes - ETH_LEN
                                                        + $urandom_range(1, 200));
                    5: p.dst = p.dst ^ (32'd1 << $urandom_range(31));
                    6: p.bad_sum = 1'b1;
                    default: p.frag = p.frag | 16'($urandom_range(1, FRAG_BITS));
                endcase
            end
            send_packet(p);
            bytes_out += p.n_bytes;
            frames_out++;
        end
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || frame_valid || verdicts_due.size() != 0)
            @(posedge clk);
        // a trailing byte may still sit in the input register
        repeat (4) @(posedge clk);
    endtask

    task automatic set_local_address(input logic [31:0] addr);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        local_address_now = addr;
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        packet_spec_t p;
        int unsigned  covered;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest legal packet, no payload
        p = sane_packet(5, 0);
        p.tlen  = 16'd20;
        p.proto = 8'h00;
        send_packet(p);
        // largest header, total length at the frame limit, df and reserved flag bits
        p = sane_packet(15, 30);
        p.tlen  = 16'(p.n_bytes - ETH_LEN);
        p.proto = 8'hFF;
        p.frag  = 16'hC000;
        send_packet(p);
        // frames that end too soon
        p = sane_packet(5, 0);
        p.n_bytes = SHORTEST_FRAME - 1;
        send_packet(p);
        p.raw     = 1'b1;
        p.n_bytes = 1;
        send_packet(p);
        // all-zero and all-ones frames
        p = sane_packet(5, 0);
        p.raw       = 1'b1;
        p.rand_fill = 1'b0;
        p.fill      = 8'h00;
        send_packet(p);
        p.n_bytes = 64;
        p.fill    = 8'hFF;
        send_packet(p);
        p = sane_packet(5, 8);
        p.etype = 16'h86DD;
        send_packet(p);
        p = sane_packet(5, 8);
        p.ver = 4'd6;
        send_packet(p);
        p = sane_packet(5, 8);
        p.ihl = 4'd4;
        send_packet(p);
        p.ihl = 4'd0;
        send_packet(p);
        p = sane_packet(15, 0);
        p.n_bytes = 60;
        send_packet(p);
        p = sane_packet(5, 10);
        p.tlen = 16'd19;
        send_packet(p);
        p.tlen = 16'(p.n_bytes - ETH_LEN + 1);
        send_packet(p);
        p = sane_packet(5, 4);
        p.dst = p.dst ^ 32'h8000_0000;
        send_packet(p);
        p = sane_packet(6, 4);
        p.bad_sum = 1'b1;
        send_packet(p);
        p = sane_packet(5, 4);
        p.frag = 16'h0001;
        send_packet(p);
        p.frag = 16'h2000;
        send_packet(p);

        set_local_address(32'hFFFF_FFFF);
        queue_random_traffic(80, 2);
        set_local_address(32'h0000_0000);
        queue_random_traffic(80, 2);
        set_local_address($urandom);
        queue_random_traffic(80, 2);
        set_local_address(BOOT_ADDRESS);
        queue_random_traffic(80, 2);

        wait_idle();
        repeat (10) @(posedge clk);

        covered = 0;
        for (int r = 0; r < 16; r++)
            covered += reasons_hit[r];
        $display("checked %0d verdicts (%0d accepted) over %0d frame bytes, %0d of 10 codes hit",
                 verdicts_seen, accepts_seen, bytes_taken, covered);
        $display("local address written %0d times: all ones, all zeros, random, reset value",
                 settings_used);
        if (errors == 0 && verdicts_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("%0t: run timed out with %0d verdicts outstanding", $time, verdicts_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== ipv4_receive_header_filter_top.f =====
rtl/ipv4rhf_pkg.sv
rtl/ipv4_receive_header_filter_top.sv
verif/tb_ipv4_receive_header_filter_top.sv
